// ----- design/iprl_pkg.sv -----
package iprl_pkg;

  // default sizes
  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned VPN_BITS_DEF = 8;
  localparam int unsigned LOC_BITS_DEF = 8;

  // word field widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned VPN_W    = 8;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LOC_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 8;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

  // answer codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request word
    logic init;      // clear find/remove scratch, latch full flag
    logic rd_en;     // table read at rd_addr
    logic eval;      // act on the entry read last cycle
    logic put_zero;  // write new range at slot 0
    logic commit;    // remove done: count takes write pointer
    logic emit;      // load the answer register
  } iprl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic             full;
    logic             empty;
    logic             stop;      // add: read entry stays in front of new one
    logic             out_busy;  // answer register held by the sink
  } iprl_stat_t;

endpackage

// ----- design/iprl_ctrl.sv -----
module iprl_ctrl #(
  parameter int unsigned ENTRIES = iprl_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  iprl_pkg::iprl_stat_t               stat_i,
  input  logic [$clog2(ENTRIES+1)-1:0]       count_i,
  output iprl_pkg::iprl_cmd_t                cmd_o,
  output logic [$clog2(ENTRIES)-1:0]         rd_addr_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_q, last_d;
  logic [IDX_W-1:0] top_idx;

  assign top_idx    = IDX_W'(count_i - CNT_W'(1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    last_d    = last_q;
    cmd_o     = '0;
    rd_addr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        cmd_o.init = 1'b1;
        case (stat_i.op)
          iprl_pkg::REQ_ADD: begin
            if (stat_i.full) begin
              state_d = S_DONE;
            end else if (stat_i.empty) begin
              cmd_o.put_zero = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = top_idx;
              idx_d       = top_idx;
              last_d      = (top_idx == '0);
              state_d     = S_SCAN;
            end
          end
          iprl_pkg::REQ_REMOVE, iprl_pkg::REQ_FIND: begin
            if (stat_i.empty) begin
              state_d = S_DONE;
            end else begin
              cmd_o.rd_en = 1'b1;
              rd_addr_o   = (stat_i.op == iprl_pkg::REQ_REMOVE) ? '0 : top_idx;
              idx_d       = rd_addr_o;
              last_d      = (top_idx == '0);
              state_d     = S_SCAN;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd_o.eval = 1'b1;
        if ((stat_i.op == iprl_pkg::REQ_ADD) && stat_i.stop) begin
          state_d = S_DONE;
        end else if (last_q) begin
          state_d = (stat_i.op == iprl_pkg::REQ_ADD) ? S_TAIL : S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          if (stat_i.op == iprl_pkg::REQ_REMOVE) begin
            rd_addr_o = idx_q + IDX_W'(1);
            last_d    = (rd_addr_o == top_idx);
          end else begin
            rd_addr_o = idx_q - IDX_W'(1);
            last_d    = (rd_addr_o == '0);
          end
          idx_d = rd_addr_o;
        end
      end
      S_TAIL: begin
        cmd_o.put_zero = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        cmd_o.commit = (stat_i.op == iprl_pkg::REQ_REMOVE);
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

endmodule

// ----- design/iprl_dpath.sv -----
module iprl_dpath #(
  parameter int unsigned ENTRIES  = iprl_pkg::ENTRIES_DEF,
  parameter int unsigned VPN_BITS = iprl_pkg::VPN_BITS_DEF,
  parameter int unsigned LOC_BITS = iprl_pkg::LOC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [iprl_pkg::REQ_W-1:0]          req_type_i,
  input  logic [iprl_pkg::VPN_W-1:0]          vpn_id_i,
  input  logic [iprl_pkg::ADDR_W-1:0]         address_i,
  input  logic [iprl_pkg::ADDR_W-1:0]         mask_i,
  input  logic [iprl_pkg::LOC_W-1:0]          location_id_i,
  input  iprl_pkg::iprl_cmd_t                 cmd_i,
  input  logic [$clog2(ENTRIES)-1:0]          rd_addr_i,
  output iprl_pkg::iprl_stat_t                stat_o,
  output logic [$clog2(ENTRIES+1)-1:0]        count_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [iprl_pkg::STATUS_W-1:0]       status_o,
  output logic [iprl_pkg::LOC_W-1:0]          match_location_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned AW    = iprl_pkg::ADDR_W;
  localparam int unsigned EW    = VPN_BITS + 2 * AW + LOC_BITS;
  localparam int unsigned UP_LSB = LOC_BITS;
  localparam int unsigned LO_LSB = LOC_BITS + AW;
  localparam int unsigned VPN_LSB = LOC_BITS + 2 * AW;

  // entry word, high to low: vpn, lower, upper, location
  logic [EW-1:0]       mem_q [ENTRIES];
  logic [EW-1:0]       rdata_q;
  logic [IDX_W-1:0]    ev_addr_q;

  logic [iprl_pkg::REQ_W-1:0] req_q;
  logic [VPN_BITS-1:0] vpn_q;
  logic [AW-1:0]       addr_q, mask_q;
  logic [LOC_BITS-1:0] loc_q;

  logic [CNT_W-1:0]    count_q, wptr_q;
  logic                full_q;
  logic [AW-1:0]       best_q;
  logic [LOC_BITS-1:0] found_q;

  logic                out_valid_q;
  logic [iprl_pkg::STATUS_W-1:0] status_q;
  logic [iprl_pkg::LOC_W-1:0]    match_q;

  logic [AW-1:0]       new_lo, new_hi;
  logic [EW-1:0]       new_entry;
  logic [VPN_BITS-1:0] r_vpn;
  logic [AW-1:0]       r_lo, r_up, r_width;
  logic [LOC_BITS-1:0] r_loc;
  logic                stop, keep, take;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [EW-1:0]       wdata;

  assign new_lo    = addr_q & mask_q;
  assign new_hi    = new_lo | ~mask_q;
  assign new_entry = {vpn_q, new_lo, new_hi, loc_q};

  assign r_vpn   = rdata_q[VPN_LSB +: VPN_BITS];
  assign r_lo    = rdata_q[LO_LSB +: AW];
  assign r_up    = rdata_q[UP_LSB +: AW];
  assign r_loc   = rdata_q[LOC_BITS-1:0];
  assign r_width = r_up - r_lo;

  // add: entry stays in front when it sorts at or before the new range
  assign stop = (r_vpn < vpn_q) || ((r_vpn == vpn_q) && (r_lo <= new_lo));
  assign keep = (r_loc != loc_q);
  // find: strict compare on a descending scan lets the later entry win ties
  assign take = (r_vpn == vpn_q) && (r_lo <= addr_q) && (r_up >= addr_q) &&
                (r_width < best_q) && keep;

  always_comb begin
    we    = 1'b0;
    waddr = ev_addr_q + IDX_W'(1);
    wdata = rdata_q;
    if (cmd_i.put_zero) begin
      we    = 1'b1;
      waddr = '0;
      wdata = new_entry;
    end else if (cmd_i.eval) begin
      case (req_q)
        iprl_pkg::REQ_ADD: begin
          we    = 1'b1;
          wdata = stop ? new_entry : rdata_q;
        end
        iprl_pkg::REQ_REMOVE: begin
          we    = keep;
          waddr = wptr_q[IDX_W-1:0];
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q   <= mem_q[rd_addr_i];
      ev_addr_q <= rd_addr_i;
    end
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      vpn_q  <= VPN_BITS'(vpn_id_i);
      addr_q <= address_i;
      mask_q <= mask_i;
      loc_q  <= LOC_BITS'(location_id_i);
    end
    if (cmd_i.init) begin
      full_q  <= (count_q == CNT_W'(ENTRIES));
      best_q  <= '1;
      found_q <= '0;
    end else if (cmd_i.eval && (req_q == iprl_pkg::REQ_FIND) && take) begin
      best_q  <= r_width;
      found_q <= r_loc;
    end
    if (cmd_i.emit) begin
      case (req_q)
        iprl_pkg::REQ_ADD: begin
          status_q <= full_q ? iprl_pkg::ST_FULL : iprl_pkg::ST_DONE;
          match_q  <= '0;
        end
        iprl_pkg::REQ_FIND: begin
          status_q <= (found_q == '0) ? iprl_pkg::ST_NOMATCH : iprl_pkg::ST_DONE;
          match_q  <= iprl_pkg::LOC_W'(found_q);
        end
        default: begin
          status_q <= iprl_pkg::ST_DONE;
          match_q  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.put_zero ||
          (cmd_i.eval && (req_q == iprl_pkg::REQ_ADD) && stop)) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.commit) begin
        count_q <= wptr_q;
      end
      if (cmd_i.init) begin
        wptr_q <= '0;
      end else if (cmd_i.eval && (req_q == iprl_pkg::REQ_REMOVE) && keep) begin
        wptr_q <= wptr_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op       = req_q;
  assign stat_o.full     = (count_q == CNT_W'(ENTRIES));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.stop     = stop;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign count_o          = count_q;
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_location_o = match_q;

endmodule

// ----- design/ip_range_location_lookup.sv -----
// Channel  | Dir | tuser              | tdata
// ---------+-----+--------------------+------------------------------------------
// s_axis   | in  | [1:0] req_type     | [7:0] vpn_id, [39:8] address,
//          |     |                    | [71:40] mask, [79:72] location_id
// m_axis   | out | [1:0] status       | [7:0] match_location
//
// One request word at a time, one answer word per request.
// Add, find and remove walk the table one stored range per cycle through
// the table RAM's single read port; add stops early at its insertion slot,
// and add on an empty or full table does not walk it.
// Reset clears the entry count but not the table; table contents are never read unwritten.
// The answer sits in an output register: a stalled m_axis holds only the
// final step, and the next request word is taken meanwhile.
module ip_range_location_lookup #(
  parameter int unsigned ENTRIES  = iprl_pkg::ENTRIES_DEF,
  parameter int unsigned VPN_BITS = iprl_pkg::VPN_BITS_DEF,
  parameter int unsigned LOC_BITS = iprl_pkg::LOC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [iprl_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // vpn_id, address, mask, location_id
  input  logic [iprl_pkg::REQ_W-1:0]        s_axis_tuser,   // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [iprl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // match_location
  output logic [iprl_pkg::STATUS_W-1:0]     m_axis_tuser    // status
);

  iprl_pkg::iprl_cmd_t              cmd;
  iprl_pkg::iprl_stat_t             stat;
  logic [$clog2(ENTRIES+1)-1:0]     count;
  logic [$clog2(ENTRIES)-1:0]       rd_addr;

  // sequencer: walks the table and steers the datapath
  iprl_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .count_i    (count),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  // table RAM, compare/select logic and answer register
  iprl_dpath #(
    .ENTRIES  (ENTRIES),
    .VPN_BITS (VPN_BITS),
    .LOC_BITS (LOC_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_type_i       (s_axis_tuser),
    .vpn_id_i         (s_axis_tdata[7:0]),
    .address_i        (s_axis_tdata[39:8]),
    .mask_i           (s_axis_tdata[71:40]),
    .location_id_i    (s_axis_tdata[79:72]),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .stat_o           (stat),
    .count_o          (count),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .status_o         (m_axis_tuser),
    .match_location_o (m_axis_tdata)
  );

endmodule

// ----- design/iprl_checker.sv -----
module iprl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [iprl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [iprl_pkg::STATUS_W-1:0]    m_axis_tuser
);

  // a held answer word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("answer word changed while stalled");

  // one request in flight: busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one in progress");

  // a location is only reported together with a found status
  a_match_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata != '0) |-> (m_axis_tuser == iprl_pkg::ST_DONE))
    else $error("location reported without found status");

  // only defined answer codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == iprl_pkg::ST_DONE) ||
                      (m_axis_tuser == iprl_pkg::ST_FULL) ||
                      (m_axis_tuser == iprl_pkg::ST_NOMATCH))
    else $error("undefined answer code");

endmodule

bind ip_range_location_lookup iprl_checker u_iprl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
